// ===== hdl/bpnf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpnf_pkg: shared types and constants for the blank pixel neighbour fill
// Holds the register indexes, request codes, controller states, the command
// and status structs between controller and datapath, and the reciprocal
// table used to divide a channel sum by the neighbour count.
// ----------------------------------------------------------------------------
package bpnf_pkg;

  localparam int DEF_MAX_HEIGHT    = 1024;
  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_FRAME_WIDTH   = 640;
  localparam int DEF_FRAME_HEIGHT  = 480;
  localparam int MIN_FRAME_DIM     = 3;

  localparam int CFG_DATA_W        = 13;
  localparam int WIDTH_REG_W       = 13;
  localparam int HEIGHT_REG_W      = 11;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [23:0] BLANK_RGB = 24'hFF_FFFF;

  // Sums of up to eight 8-bit channels, counts of up to eight neighbours.
  localparam int ACC_W       = 11;
  localparam int NCNT_W      = 4;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 14;
  localparam int PROD_W      = ACC_W + RECIP_W;

  localparam logic [2:0] GATHER_LAST = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_LOAD,
    ST_GATHER,
    ST_DIVIDE,
    ST_WRITE
  } state_e;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_e;

  typedef struct packed {
    logic       push;
    logic       load;
    logic       gather;
    logic [2:0] step;
    logic       divide;
    chan_e      ch;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic pop_after_push;
    logic interior;
  } status_t;

  // ceil(2^14 / n) is exact for truncating division of 11-bit sums by 1..8.
  function automatic logic [RECIP_W-1:0] recip(input logic [NCNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 15'd16384;
      4'd2:    r = 15'd8192;
      4'd3:    r = 15'd5462;
      4'd4:    r = 15'd4096;
      4'd5:    r = 15'd3277;
      4'd6:    r = 15'd2731;
      4'd7:    r = 15'd2341;
      4'd8:    r = 15'd2048;
      default: r = 15'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bpnf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpnf_ctrl: sequencing state machine
// Accepts words, steps the datapath through head read, neighbour gather,
// per-channel divide and write back, and owns the result valid flag.
// ----------------------------------------------------------------------------
module bpnf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              req_type_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire bpnf_pkg::status_t status_i,
  output bpnf_pkg::cmd_t         cmd_o
);

  bpnf_pkg::state_e state_q, state_d;
  logic [2:0]       step_q, step_d;
  bpnf_pkg::chan_e  ch_q, ch_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpnf_pkg::ST_IDLE;
      step_q      <= '0;
      ch_q        <= bpnf_pkg::CH_RED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ch_d    = ch_q;
    case (state_q)
      bpnf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == bpnf_pkg::REQ_FLUSH) begin
            if (!status_i.count_zero) state_d = bpnf_pkg::ST_HEAD;
          end else if (status_i.pop_after_push) begin
            state_d = bpnf_pkg::ST_HEAD;
          end
        end
      end
      bpnf_pkg::ST_HEAD: state_d = bpnf_pkg::ST_LOAD;
      bpnf_pkg::ST_LOAD: begin
        step_d  = '0;
        state_d = status_i.interior ? bpnf_pkg::ST_GATHER : bpnf_pkg::ST_WRITE;
      end
      bpnf_pkg::ST_GATHER: begin
        step_d = step_q + 3'd1;
        if (step_q == bpnf_pkg::GATHER_LAST) begin
          state_d = bpnf_pkg::ST_DIVIDE;
          ch_d    = bpnf_pkg::CH_RED;
        end
      end
      bpnf_pkg::ST_DIVIDE: begin
        case (ch_q)
          bpnf_pkg::CH_RED:   ch_d = bpnf_pkg::CH_GREEN;
          bpnf_pkg::CH_GREEN: ch_d = bpnf_pkg::CH_BLUE;
          default: begin
            ch_d    = bpnf_pkg::CH_RED;
            state_d = bpnf_pkg::ST_WRITE;
          end
        endcase
      end
      bpnf_pkg::ST_WRITE: begin
        if (out_free) state_d = bpnf_pkg::ST_IDLE;
      end
      default: state_d = bpnf_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd_o       = '0;
    cmd_o.step  = step_q;
    cmd_o.ch    = ch_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      bpnf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.push = in_valid_i && (req_type_i == bpnf_pkg::REQ_PIXEL);
      end
      bpnf_pkg::ST_LOAD:   cmd_o.load   = 1'b1;
      bpnf_pkg::ST_GATHER: cmd_o.gather = 1'b1;
      bpnf_pkg::ST_DIVIDE: cmd_o.divide = 1'b1;
      bpnf_pkg::ST_WRITE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== hdl/bpnf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpnf_datapath: pending pixel queue, column store and averaging unit
// Holds the raw pixel queue with coordinates, the processed previous and
// current column, the scan position, the neighbour accumulator and the
// result register.
// ----------------------------------------------------------------------------
module bpnf_datapath #(
  parameter int MAX_HEIGHT = bpnf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = bpnf_pkg::DEF_MAX_WIDTH,
  localparam int WW        = $clog2(MAX_WIDTH + 1),
  localparam int HW        = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [WW-1:0]     frame_width_i,
  input  wire logic [HW-1:0]     frame_height_i,
  input  wire bpnf_pkg::cmd_t    cmd_i,
  output bpnf_pkg::status_t      status_o,
  input  wire logic [7:0]        red_in_i,
  input  wire logic [7:0]        green_in_i,
  input  wire logic [7:0]        blue_in_i,
  output logic [7:0]             red_out_o,
  output logic [7:0]             green_out_o,
  output logic [7:0]             blue_out_o,
  output logic                   was_filled_o,
  output logic                   frame_last_o
);

  localparam int DEPTH = MAX_HEIGHT + 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DAW   = $clog2(2 * MAX_HEIGHT);
  localparam int EW    = 24 + YW + XW + 1;
  localparam int AW    = bpnf_pkg::ACC_W;
  localparam int NW    = bpnf_pkg::NCNT_W;

  function automatic logic [PW-1:0] wrap_ptr(input logic [PW:0] s);
    logic [PW:0] t;
    t = s - (PW+1)'(DEPTH);
    return (s >= (PW+1)'(DEPTH)) ? t[PW-1:0] : s[PW-1:0];
  endfunction

  // Pending queue memory and its pointers.
  logic [EW-1:0]   fifo_mem [DEPTH];
  logic [EW-1:0]   fifo_rdata_q;
  logic [PW-1:0]   fifo_raddr, tail_ptr, head_inc;
  logic [PW-1:0]   head_q;
  logic [CNTW-1:0] count_q, count_pushed;
  logic            full;

  // Scan position.
  logic [YW-1:0]   row_q, row_next;
  logic [XW-1:0]   col_q, col_next;
  logic [HW-1:0]   row_inc;
  logic [WW-1:0]   col_inc, col_cand;
  logic            row_wrap, push_last;

  // Column store.
  logic [23:0]     done_mem [2 * MAX_HEIGHT];
  logic [23:0]     done_rdata_q;
  logic [DAW-1:0]  d_addr, w_addr;
  logic [YW-1:0]   d_y;
  logic            d_sel;
  logic            sel_q, tag_valid_q;
  logic [XW-1:0]   tag_q;

  // Current entry.
  logic [23:0]     rd_rgb, e_rgb_q;
  logic [YW-1:0]   rd_y, e_y_q;
  logic [XW-1:0]   rd_x, e_x_q;
  logic            rd_last, e_last_q, interior_q;

  // Neighbour lookups in the queue.
  logic [CNTW-1:0] p_off;
  logic [PW-1:0]   p_addr;
  logic [XW-1:0]   p_ex, p_ex_q;
  logic [YW-1:0]   p_ey, p_ey_q;
  logic            p_ok_q;

  // Accumulator and divider.
  logic [NW-1:0]   acc_n_q;
  logic [AW-1:0]   acc_r_q, acc_g_q, acc_b_q, div_sum;
  logic [bpnf_pkg::PROD_W-1:0] prod;
  logic [7:0]      avg_r_q, avg_g_q, avg_b_q, quot;
  logic            d_hit, p_hit, use_avg;
  logic [23:0]     pix;

  assign rd_rgb  = fifo_rdata_q[23:0];
  assign rd_y    = fifo_rdata_q[24 +: YW];
  assign rd_x    = fifo_rdata_q[24 + YW +: XW];
  assign rd_last = fifo_rdata_q[EW-1];

  assign full         = (count_q == CNTW'(DEPTH));
  assign count_pushed = full ? count_q : count_q + CNTW'(1);
  assign tail_ptr     = wrap_ptr((PW+1)'(head_q) + (PW+1)'(count_q));
  assign head_inc     = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);

  assign status_o.count_zero     = (count_q == '0);
  assign status_o.pop_after_push =
      (CNTW+1)'(count_pushed) > ((CNTW+1)'(frame_height_i) + (CNTW+1)'(1));
  assign status_o.interior =
      (rd_rgb == bpnf_pkg::BLANK_RGB) && (rd_x != '0) && (rd_y != '0) &&
      ((WW+1)'(rd_x) + (WW+1)'(2) <= (WW+1)'(frame_width_i)) &&
      ((HW+1)'(rd_y) + (HW+1)'(2) <= (HW+1)'(frame_height_i));

  // Position advance after a pixel, wrapping at the current bounds.
  assign row_inc   = HW'(row_q) + HW'(1);
  assign col_inc   = WW'(col_q) + WW'(1);
  assign row_wrap  = (row_inc >= frame_height_i);
  assign col_cand  = row_wrap ? col_inc : WW'(col_q);
  assign row_next  = row_wrap ? '0 : row_inc[YW-1:0];
  assign col_next  = (col_cand >= frame_width_i) ? '0 : col_cand[XW-1:0];
  assign push_last = (col_inc == frame_width_i) && (row_inc == frame_height_i);

  // Gather schedule: three cells of the previous column and the cell above from
  // the column store, beside the cell below and three next-column queue cells.
  always_comb begin
    d_y   = e_y_q;
    d_sel = ~sel_q;
    p_off = CNTW'(1);
    p_ex  = e_x_q + XW'(1);
    p_ey  = e_y_q;
    case (cmd_i.step)
      3'd0: begin
        d_y   = e_y_q - YW'(1);
        p_ex  = e_x_q;
        p_ey  = e_y_q + YW'(1);
      end
      3'd1: begin
        p_off = CNTW'(frame_height_i) - CNTW'(1);
        p_ey  = e_y_q - YW'(1);
      end
      3'd2: begin
        d_y   = e_y_q + YW'(1);
        p_off = CNTW'(frame_height_i);
      end
      3'd3: begin
        d_y   = e_y_q - YW'(1);
        d_sel = sel_q;
        p_off = CNTW'(frame_height_i) + CNTW'(1);
        p_ey  = e_y_q + YW'(1);
      end
      default: ;
    endcase
  end

  assign p_addr     = wrap_ptr((PW+1)'(head_q) + (PW+1)'(p_off));
  assign fifo_raddr = cmd_i.gather ? p_addr : head_q;
  assign d_addr     = d_sel ? DAW'(d_y) + DAW'(MAX_HEIGHT) : DAW'(d_y);
  assign w_addr     = sel_q ? DAW'(e_y_q) + DAW'(MAX_HEIGHT) : DAW'(e_y_q);

  assign use_avg = interior_q && (acc_n_q != '0);
  assign pix     = use_avg ? {avg_r_q, avg_g_q, avg_b_q} : e_rgb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      fifo_mem[tail_ptr] <= {push_last, col_q, row_q, red_in_i, green_in_i, blue_in_i};
    end
    fifo_rdata_q <= fifo_mem[fifo_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      done_mem[w_addr] <= pix;
    end
    done_rdata_q <= done_mem[d_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      sel_q       <= 1'b0;
      tag_valid_q <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        count_q <= count_pushed;
        if (full) head_q <= head_inc;
        row_q <= row_next;
        col_q <= col_next;
      end else if (cmd_i.finish) begin
        count_q <= count_q - CNTW'(1);
        head_q  <= head_inc;
      end
      if (cmd_i.load && (!tag_valid_q || rd_x != tag_q)) begin
        sel_q       <= ~sel_q;
        tag_valid_q <= 1'b1;
      end
    end
  end

  assign d_hit = (done_rdata_q != bpnf_pkg::BLANK_RGB);
  assign p_hit = p_ok_q && (rd_x == p_ex_q) && (rd_y == p_ey_q) &&
                 (rd_rgb != bpnf_pkg::BLANK_RGB);

  always_comb begin
    case (cmd_i.ch)
      bpnf_pkg::CH_RED:   div_sum = acc_r_q;
      bpnf_pkg::CH_GREEN: div_sum = acc_g_q;
      default:            div_sum = acc_b_q;
    endcase
  end

  assign prod = bpnf_pkg::PROD_W'(div_sum) * bpnf_pkg::PROD_W'(bpnf_pkg::recip(acc_n_q));
  assign quot = prod[bpnf_pkg::RECIP_SHIFT +: 8];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tag_q      <= rd_x;
      e_rgb_q    <= rd_rgb;
      e_x_q      <= rd_x;
      e_y_q      <= rd_y;
      e_last_q   <= rd_last;
      interior_q <= status_o.interior;
      acc_n_q    <= '0;
      acc_r_q    <= '0;
      acc_g_q    <= '0;
      acc_b_q    <= '0;
    end
    if (cmd_i.gather) begin
      p_ok_q <= (p_off < count_q);
      p_ex_q <= p_ex;
      p_ey_q <= p_ey;
      if (cmd_i.step != 3'd0) begin
        acc_n_q <= acc_n_q + NW'(d_hit) + NW'(p_hit);
        acc_r_q <= acc_r_q + (d_hit ? AW'(done_rdata_q[23:16]) : '0)
                           + (p_hit ? AW'(rd_rgb[23:16]) : '0);
        acc_g_q <= acc_g_q + (d_hit ? AW'(done_rdata_q[15:8]) : '0)
                           + (p_hit ? AW'(rd_rgb[15:8]) : '0);
        acc_b_q <= acc_b_q + (d_hit ? AW'(done_rdata_q[7:0]) : '0)
                           + (p_hit ? AW'(rd_rgb[7:0]) : '0);
      end
    end
    if (cmd_i.divide) begin
      case (cmd_i.ch)
        bpnf_pkg::CH_RED:   avg_r_q <= quot;
        bpnf_pkg::CH_GREEN: avg_g_q <= quot;
        default:            avg_b_q <= quot;
      endcase
    end
    if (cmd_i.finish) begin
      red_out_o    <= pix[23:16];
      green_out_o  <= pix[15:8];
      blue_out_o   <= pix[7:0];
      was_filled_o <= use_avg;
      frame_last_o <= e_last_q;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/blank_pixel_neighbour_fill.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blank_pixel_neighbour_fill: 3x3 neighbour average hole filling
// Pixels arrive column by column. A blank interior pixel (all channels 255)
// is replaced by the truncated per-channel mean of its non-blank neighbours;
// results leave frame_height+1 pixels later, and flush words drain them.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                 Word
//  -------   -----------------------   ------------------------------------
//  input     in_valid_i / in_ready_o   req_type, red/green/blue_in
//  output    out_valid_o / out_ready_i red/green/blue_out, was_filled,
//                                      frame_last
//  config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A word that produces no result is taken in idle. A word that pops a border
// or non-blank pixel passes head read, load and write back; a blank interior
// pixel also passes a neighbour gather on the single read ports of queue and
// column store (four reads each) and three divides on one shared multiplier.
// Reset clears the queue count, scan position and valid flag; memory contents
// need no clearing. A stalled output holds the result, and the block still
// accepts a next word until it has a new result to place.
//
module blank_pixel_neighbour_fill #(
  parameter int MAX_HEIGHT = bpnf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH  = bpnf_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            req_type_i,
  input  wire logic [7:0]                      red_in_i,
  input  wire logic [7:0]                      green_in_i,
  input  wire logic [7:0]                      blue_in_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [7:0]                           red_out_o,
  output logic [7:0]                           green_out_o,
  output logic [7:0]                           blue_out_o,
  output logic                                 was_filled_o,
  output logic                                 frame_last_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [0:0]                      cfg_index_i,
  input  wire logic [bpnf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RST_WIDTH  = (MAX_WIDTH < bpnf_pkg::DEF_FRAME_WIDTH) ?
                              MAX_WIDTH : bpnf_pkg::DEF_FRAME_WIDTH;
  localparam int RST_HEIGHT = (MAX_HEIGHT < bpnf_pkg::DEF_FRAME_HEIGHT) ?
                              MAX_HEIGHT : bpnf_pkg::DEF_FRAME_HEIGHT;

  logic [WW-1:0] frame_width_q, frame_width_d;
  logic [HW-1:0] frame_height_q, frame_height_d;
  logic [31:0]   wr_w, wr_h, clamp_w, clamp_h;

  bpnf_pkg::cmd_t    cmd;
  bpnf_pkg::status_t status;

  // Configuration is always taken; out-of-range values clamp to 3..max.
  assign cfg_ready_o = 1'b1;

  assign wr_w = 32'(cfg_data_i[bpnf_pkg::WIDTH_REG_W-1:0]);
  assign wr_h = 32'(cfg_data_i[bpnf_pkg::HEIGHT_REG_W-1:0]);

  always_comb begin
    clamp_w = wr_w;
    if (wr_w < 32'(bpnf_pkg::MIN_FRAME_DIM)) clamp_w = 32'(bpnf_pkg::MIN_FRAME_DIM);
    if (wr_w > 32'(MAX_WIDTH))               clamp_w = 32'(MAX_WIDTH);
    clamp_h = wr_h;
    if (wr_h < 32'(bpnf_pkg::MIN_FRAME_DIM)) clamp_h = 32'(bpnf_pkg::MIN_FRAME_DIM);
    if (wr_h > 32'(MAX_HEIGHT))              clamp_h = 32'(MAX_HEIGHT);
  end

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bpnf_pkg::REG_FRAME_WIDTH:  frame_width_d  = clamp_w[WW-1:0];
        bpnf_pkg::REG_FRAME_HEIGHT: frame_height_d = clamp_h[HW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WW'(RST_WIDTH);
      frame_height_q <= HW'(RST_HEIGHT);
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  // The controller sequences each popped pixel; the datapath owns the pixel storage.
  bpnf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bpnf_datapath #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .cmd_i          (cmd),
    .status_o       (status),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .was_filled_o   (was_filled_o),
    .frame_last_o   (frame_last_o)
  );

endmodule
`default_nettype wire
